### src/rsbm_pkg.sv
// Shared types and constants for the ROM/SRAM bank mapper.
// No dependencies; imported by rsbm_map and rom_sram_bank_mapper.
`default_nettype none

package rsbm_pkg;

    localparam int NUM_BANKS   = 3;
    localparam int BANK_IDX_W  = 2;
    localparam int PAGE_W      = 4;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int ROM_ADDR_W  = 17;
    localparam int SRAM_ADDR_W = 13;
    localparam int TARGET_W    = 2;

    // Upper address nibble (4 KB block) codes used by the decoder
    localparam logic [3:0] BLK_ROM0_LO = 4'h4;
    localparam logic [3:0] BLK_ROM0_HI = 4'h5;
    localparam logic [3:0] BLK_BANK0   = 4'h6;
    localparam logic [3:0] BLK_BANK0_M = 4'h7;
    localparam logic [3:0] BLK_BANK1   = 4'h8;
    localparam logic [3:0] BLK_BANK1_M = 4'h9;
    localparam logic [3:0] BLK_BANK2   = 4'hA;
    localparam logic [3:0] BLK_SRAM_WR = 4'hB;

    // Data bits of a bank select word
    localparam int SEL_SRAM_BIT = 4;
    localparam int SEL_HALF_BIT = 5;

    // Read source codes
    localparam logic [TARGET_W-1:0] TARGET_NONE = 2'd0;
    localparam logic [TARGET_W-1:0] TARGET_ROM  = 2'd1;
    localparam logic [TARGET_W-1:0] TARGET_SRAM = 2'd2;

    // Access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } access_t;

    typedef struct packed {
        logic [TARGET_W-1:0]    target;
        logic [ROM_ADDR_W-1:0]  rom_address;
        logic [SRAM_ADDR_W-1:0] sram_address;
        logic                   sram_write;
        logic [DATA_W-1:0]      write_data;
    } result_t;

    // ROM page held by a bank after reset: banks map pages 1, 2, 3
    function automatic logic [PAGE_W-1:0] reset_page(input logic [BANK_IDX_W-1:0] idx);
        reset_page = PAGE_W'(idx) + PAGE_W'(1);
    endfunction

endpackage

`default_nettype wire

### src/rsbm_map.sv
// Bank registers and address decode of the ROM/SRAM bank mapper.
// Depends on rsbm_pkg; instantiated by rom_sram_bank_mapper.
`default_nettype none

module rsbm_map
    import rsbm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    step,      // access leaves the input register this cycle
    input  wire access_t acc,
    output result_t      res
);

    logic              bank_is_sram_reg   [NUM_BANKS];
    logic [PAGE_W-1:0] bank_rom_page_reg  [NUM_BANKS];
    logic              bank_sram_half_reg [NUM_BANKS];
    logic              last_sram_half_reg;
    logic              sram_write_enabled_reg;

    logic [3:0]            blk;
    logic [BANK_IDX_W-1:0] bank_idx;
    logic                  in_bank;
    logic                  sel_write;
    logic                  sel_sram;
    logic                  sel_half;

    assign blk      = acc.address[ADDR_W-1:ADDR_W-4];
    assign sel_sram = acc.data[SEL_SRAM_BIT];
    assign sel_half = acc.data[SEL_HALF_BIT];

    // Work out which switchable bank the block belongs to
    always_comb begin
        bank_idx  = '0;
        in_bank   = 1'b0;
        sel_write = 1'b0;
        case (blk)
            BLK_BANK0: begin
                bank_idx  = 2'd0;
                in_bank   = 1'b1;
                sel_write = 1'b1;
            end
            BLK_BANK0_M: begin
                bank_idx = 2'd0;
                in_bank  = 1'b1;
            end
            BLK_BANK1: begin
                bank_idx  = 2'd1;
                in_bank   = 1'b1;
                sel_write = 1'b1;
            end
            BLK_BANK1_M: begin
                bank_idx = 2'd1;
                in_bank  = 1'b1;
            end
            BLK_BANK2: begin
                bank_idx  = 2'd2;
                in_bank   = 1'b1;
                sel_write = 1'b1;
            end
            BLK_SRAM_WR: begin
                bank_idx = 2'd2;
                in_bank  = 1'b1;
            end
            default: begin
                bank_idx  = '0;
                in_bank   = 1'b0;
                sel_write = 1'b0;
            end
        endcase
    end

    // Form the result word from the current bank state
    always_comb begin
        res = '0;
        if (acc.op == OP_READ) begin
            if (blk == BLK_ROM0_LO || blk == BLK_ROM0_HI) begin
                res.target      = TARGET_ROM;
                res.rom_address = {PAGE_W'(0), acc.address[12:0]};
            end else if (in_bank) begin
                if (bank_is_sram_reg[bank_idx]) begin
                    res.target       = TARGET_SRAM;
                    res.sram_address = {bank_sram_half_reg[bank_idx], acc.address[11:0]};
                end else begin
                    res.target      = TARGET_ROM;
                    res.rom_address = {bank_rom_page_reg[bank_idx], acc.address[12:0]};
                end
            end
        end else if (blk == BLK_SRAM_WR && sram_write_enabled_reg) begin
            res.sram_write   = 1'b1;
            res.sram_address = {last_sram_half_reg, acc.address[11:0]};
            res.write_data   = acc.data;
        end
    end

    // Update bank selection on select writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_BANKS; k++) begin
                bank_is_sram_reg[k]   <= 1'b0;
                bank_rom_page_reg[k]  <= reset_page(BANK_IDX_W'(k));
                bank_sram_half_reg[k] <= 1'b0;
            end
            last_sram_half_reg     <= 1'b0;
            sram_write_enabled_reg <= 1'b0;
        end else if (step && acc.op == OP_WRITE && sel_write) begin
            if (blk == BLK_BANK2) begin
                sram_write_enabled_reg <= sel_sram;
            end
            bank_is_sram_reg[bank_idx] <= sel_sram;
            if (sel_sram) begin
                last_sram_half_reg           <= sel_half;
                bank_sram_half_reg[bank_idx] <= sel_half;
            end else begin
                bank_rom_page_reg[bank_idx] <= acc.data[PAGE_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

### src/rom_sram_bank_mapper.sv
// Top level of the ROM/SRAM cartridge bank mapper: input and result registers.
// Depends on rsbm_pkg and rsbm_map.
//
// Usage:
//   Each word on the s_ channel is one CPU bus access: s_tuser[0] is the
//   access kind (0 read, 1 write), s_tdata holds address and write byte.
//   Each access yields exactly one word on the m_ channel: m_tuser carries
//   the read source and the SRAM write strobe, m_tdata the ROM address, the
//   SRAM address and the byte to store.
//   An accepted word is held in the input register, and its decode is
//   stored in the result register once that register is free.
//   Throughput is one access per cycle while the receiver does not stall.
//   Bank select writes take effect for the access that follows them.
//   Reset maps ROM pages 1, 2, 3 into the three banks, disables SRAM
//   writes and empties both registers.
//   When the receiver stalls, the result word holds; the input register
//   still takes one more word, after which s_tready drops until m_tready.
`default_nettype none

module rom_sram_bank_mapper
    import rsbm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] address, [23:16] data
    input  wire logic [0:0]  s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [16:0] rom_address, [29:17] sram_address,
                                        // [37:30] write_data, [39:38] zero
    output logic [2:0]       m_tuser    // [1:0] target, [2] sram_write
);

    logic    in_valid_reg;
    access_t in_acc_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic    out_free;
    logic    advance;
    result_t res;

    // Advance when the result register is empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    rsbm_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .acc     (in_acc_reg),
        .res     (res)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_acc_reg.op      <= s_tuser[0];
            in_acc_reg.address <= s_tdata[15:0];
            in_acc_reg.data    <= s_tdata[23:16];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.write_data, out_res_reg.sram_address,
                       out_res_reg.rom_address};
    assign m_tuser  = {out_res_reg.sram_write, out_res_reg.target};

`ifndef SYNTH
    // Input side stalls only behind a held result word
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without a stalled result");

    // An SRAM store never reports a read source
    a_write_no_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == TARGET_NONE))
        else $error("SRAM store with non-zero target");

    // ROM and SRAM addresses are never both in use
    a_addr_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == TARGET_ROM) |-> (m_tdata[29:17] == '0))
        else $error("ROM read with SRAM address set");

    // An access accepted while m_tready is high must pass through the input register into the result register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready && (!m_tvalid || m_tready)) |=> ##1 m_tvalid)
        else $error("accepted access did not produce a result");
`endif

endmodule

`default_nettype wire
